[sv/sha1sh_pkg.sv]
// Shared types and constants for the SHA-1 stream hasher.
package sha1sh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] chain_t;

    // Command codes carried in the input tuser field.
    typedef enum logic [1:0]
    {
        FUNC_START  = 2'd0,
        FUNC_ABSORB = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam word_t IV_H0 = 32'h67452301;
    localparam word_t IV_H1 = 32'hEFCDAB89;
    localparam word_t IV_H2 = 32'h98BADCFE;
    localparam word_t IV_H3 = 32'h10325476;
    localparam word_t IV_H4 = 32'hC3D2E1F0;

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    // Requests from the controller to the compression engine.
    typedef struct packed
    {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_byte;
        logic       init;
        logic       go;
    } eng_ctrl_t;

endpackage

[sv/sha1sh_engine.sv]
// Block buffer memory, message schedule and 80-round compression with chaining words.
module sha1sh_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha1sh_pkg::eng_ctrl_t ctrl,
    output logic                  busy,
    output sha1sh_pkg::chain_t    chain
);

    typedef enum logic [1:0]
    {
        E_IDLE,
        E_ROUND,
        E_ADD
    } estate_t;

    estate_t             state_reg;
    logic [6:0]          rnd_reg;
    sha1sh_pkg::chain_t  chain_reg;
    sha1sh_pkg::word_t   a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1sh_pkg::word_t   w_sh_reg [16];

    // Sixteen big-endian words; byte 4i sits in the top lane of word i.
    logic [31:0]         mem [16];
    logic [31:0]         rd_data_reg;
    logic [3:0]          rd_addr;

    sha1sh_pkg::word_t   w_mix, w_cur, f_val, k_val, a_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr[5:2]][{~ctrl.wr_addr[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Word r+1 is fetched during round r, so it is ready for the next round.
    assign rd_addr = (state_reg == E_ROUND) ? (rnd_reg[3:0] + 4'd1) : 4'd0;

    always_comb
    begin
        w_mix = w_sh_reg[13] ^ w_sh_reg[8] ^ w_sh_reg[2] ^ w_sh_reg[0];
        w_cur = (rnd_reg < 7'd16) ? rd_data_reg : {w_mix[30:0], w_mix[31]};
        if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1sh_pkg::K_0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1sh_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_3;
        end
        a_next = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + k_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            rnd_reg   <= '0;
            chain_reg <= {sha1sh_pkg::IV_H4, sha1sh_pkg::IV_H3, sha1sh_pkg::IV_H2,
                          sha1sh_pkg::IV_H1, sha1sh_pkg::IV_H0};
        end
        else
        begin
            unique case (state_reg)
                E_IDLE:
                begin
                    if (ctrl.init)
                    begin
                        chain_reg <= {sha1sh_pkg::IV_H4, sha1sh_pkg::IV_H3,
                                      sha1sh_pkg::IV_H2, sha1sh_pkg::IV_H1,
                                      sha1sh_pkg::IV_H0};
                    end
                    if (ctrl.go)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= E_ROUND;
                    end
                end
                E_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == sha1sh_pkg::LAST_ROUND)
                    begin
                        state_reg <= E_ADD;
                    end
                end
                E_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    state_reg    <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    // Working variables and schedule window need no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && ctrl.go)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (state_reg == E_ROUND)
        begin
            a_reg <= a_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                w_sh_reg[i] <= w_sh_reg[i + 1];
            end
            w_sh_reg[15] <= w_cur;
        end
    end

    assign busy  = (state_reg != E_IDLE);
    assign chain = chain_reg;

`ifndef NO_ASSERTIONS
    a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && state_reg == E_IDLE) |=> (state_reg == E_ROUND && rnd_reg == 7'd0))
        else $error("compression did not start after go");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> !busy)
        else $error("block buffer written during compression");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_ROUND) |-> (rnd_reg <= sha1sh_pkg::LAST_ROUND))
        else $error("round counter out of range");
`endif

endmodule

[sv/sha1_stream_hasher.sv]
// Top level of the SHA-1 stream hasher: command handling, padding and digest output.
//
//  channel  | dir | transfer                  | payload
//  ---------+-----+---------------------------+--------------------------------------------
//  s_*      | in  | one command               | tuser: func; tdata: data_byte
//  m_*      | out | one digest word or error  | tdata: digest_word, word_index; tlast; tuser
//
// Start, a dropped byte and a plain absorb leave the input open. The byte that fills a
// block starts the engine, which runs one round per cycle and adds the chaining words;
// the input stays closed until it is idle again. A first finish writes the padding one
// byte per cycle into the block buffer and compresses one or two blocks; a finish then
// sends five digest words, or one error word. Output stalls hold only the digest
// emission; reset is asynchronous and loads the initial chaining words with no sweep.
module sha1_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast,   // last_word
    output logic [0:0]  m_tuser    // [0] error_flag
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_PAD,
        S_CWAIT,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [5:0]             fill_reg;
    logic [60:0]            byte_cnt_reg;
    logic                   done_reg;
    logic                   bad_reg;
    logic [5:0]             pad_pos_reg;
    logic                   first_reg;
    logic                   len_blk_reg;
    logic                   err_mode_reg;
    logic [2:0]             idx_reg;
    logic                   m_valid_reg;
    logic [31:0]            m_word_reg;
    logic [2:0]             m_index_reg;
    logic                   m_last_reg;
    logic                   m_err_reg;

    sha1sh_pkg::eng_ctrl_t  ctrl;
    sha1sh_pkg::chain_t     chain;
    logic                   eng_busy;

    logic                   s_accept;
    sha1sh_pkg::func_t      func;
    logic                   absorb_ok;
    logic [60:0]            byte_cnt_next;
    logic [7:0][7:0]        len_arr;
    logic [7:0]             pad_byte;
    logic                   out_free;
    logic                   emit_last;
    logic                   emit_fire;

    assign s_tready      = (state_reg == S_IDLE) && !eng_busy;
    assign s_accept      = s_tvalid && s_tready;
    assign func          = sha1sh_pkg::func_t'(s_tuser);
    assign absorb_ok     = !done_reg && !bad_reg;
    assign byte_cnt_next = byte_cnt_reg + 61'd1;
    assign len_arr       = {byte_cnt_reg, 3'b000};
    assign out_free      = !m_valid_reg || m_tready;
    assign emit_last     = err_mode_reg || (idx_reg == sha1sh_pkg::LAST_INDEX);
    assign emit_fire     = (state_reg == S_EMIT) && out_free;

    // The length block carries the big-endian bit count in its last eight bytes.
    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = sha1sh_pkg::PAD_BYTE;
        end
        else if (len_blk_reg && pad_pos_reg[5:3] == 3'b111)
        begin
            pad_byte = len_arr[~pad_pos_reg[2:0]];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        ctrl = '0;
        if (s_accept && func == sha1sh_pkg::FUNC_START)
        begin
            ctrl.init = 1'b1;
        end
        else if (s_accept && func == sha1sh_pkg::FUNC_ABSORB && absorb_ok)
        begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = fill_reg;
            ctrl.wr_byte = s_tdata;
            ctrl.go      = (fill_reg == 6'd63);
        end
        else if (state_reg == S_PAD)
        begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = pad_pos_reg;
            ctrl.wr_byte = pad_byte;
            ctrl.go      = (pad_pos_reg == 6'd63);
        end
    end

    sha1sh_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .busy  (eng_busy),
        .chain (chain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            byte_cnt_reg <= '0;
            done_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            pad_pos_reg  <= '0;
            first_reg    <= 1'b0;
            len_blk_reg  <= 1'b0;
            err_mode_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_word_reg   <= '0;
            m_index_reg  <= '0;
            m_last_reg   <= 1'b0;
            m_err_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !emit_fire)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        unique case (func)
                            sha1sh_pkg::FUNC_START:
                            begin
                                fill_reg     <= '0;
                                byte_cnt_reg <= '0;
                                done_reg     <= 1'b0;
                                bad_reg      <= 1'b0;
                            end
                            sha1sh_pkg::FUNC_ABSORB:
                            begin
                                if (!absorb_ok)
                                begin
                                    bad_reg <= 1'b1;
                                end
                                else
                                begin
                                    fill_reg     <= fill_reg + 6'd1;
                                    byte_cnt_reg <= byte_cnt_next;
                                    if (byte_cnt_next == '0)
                                    begin
                                        bad_reg <= 1'b1;
                                    end
                                end
                            end
                            sha1sh_pkg::FUNC_FINISH:
                            begin
                                idx_reg      <= '0;
                                err_mode_reg <= bad_reg;
                                if (bad_reg || done_reg)
                                begin
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    done_reg    <= 1'b1;
                                    pad_pos_reg <= fill_reg;
                                    first_reg   <= 1'b1;
                                    len_blk_reg <= (fill_reg < 6'd56);
                                    state_reg   <= S_PAD;
                                end
                            end
                            sha1sh_pkg::FUNC_NONE:
                            begin
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PAD:
                begin
                    first_reg   <= 1'b0;
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                    if (pad_pos_reg == 6'd63)
                    begin
                        state_reg <= S_CWAIT;
                    end
                end
                S_CWAIT:
                begin
                    // The engine is already busy in the first cycle here.
                    if (!eng_busy)
                    begin
                        if (len_blk_reg)
                        begin
                            fill_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            len_blk_reg <= 1'b1;
                            pad_pos_reg <= '0;
                            state_reg   <= S_PAD;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_word_reg  <= err_mode_reg ? 32'd0 : chain[idx_reg];
                        m_index_reg <= idx_reg;
                        m_last_reg  <= emit_last;
                        m_err_reg   <= err_mode_reg;
                        idx_reg     <= idx_reg + 3'd1;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_index_reg, m_word_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

`ifndef NO_ASSERTIONS
    a_ready_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !eng_busy)
        else $error("input open while compression runs");
    a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && func == sha1sh_pkg::FUNC_FINISH) |=> !s_tready)
        else $error("input open right after a finish");
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_last_reg) |-> (m_err_reg || m_index_reg == sha1sh_pkg::LAST_INDEX))
        else $error("last flag on a word other than the fifth");
`endif

endmodule

[dv/sha1_digest_check_pkg.sv]
// Digest predictor and result scoreboard for the SHA-1 stream hasher testbench.
package sha1_digest_check_pkg;

    import sha1sh_pkg::*;

    typedef struct
    {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        err;
    } digest_out_t;

    class digest_tracker;

        logic [31:0] chain [5];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] bit_total;
        logic        done;
        logic        bad;

        digest_out_t expected_words[$];
        int          mismatches;
        int          words_seen;
        int          digests;
        int          error_results;
        int          bytes_in;

        function new();
            restart();
            mismatches = 0;
            words_seen = 0;
            digests = 0;
            error_results = 0;
            bytes_in = 0;
        endfunction

        function void restart();
            chain[0] = IV_H0;
            chain[1] = IV_H1;
            chain[2] = IV_H2;
            chain[3] = IV_H3;
            chain[4] = IV_H4;
            fill = 0;
            bit_total = '0;
            done = 1'b0;
            bad = 1'b0;
        endfunction

        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            int i;
            for (i = 0; i < 16; i++)
                w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
            for (i = 16; i < 80; i++)
            begin
                x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
                w[i] = {x[30:0], x[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K_0;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = K_1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K_3;
                end
                t = {a[26:0], a[31:27]} + f + e + w[i] + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
            fill = 0;
        endfunction

        function void pad_message();
            int pos;
            int i;
            pos = fill & 63;
            blk[pos] = PAD_BYTE;
            pos++;
            // Not enough room for the length field: pad out and compress an extra block.
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (i = 0; i < 8; i++)
                blk[56 + i] = bit_total[63 - 8 * i -: 8];
            compress();
        endfunction

        // Updates the predicted state for one accepted command and queues its results.
        function void note_command(func_t f, logic [7:0] d);
            digest_out_t r;
            int i;
            case (f)
                FUNC_START:
                    restart();
                FUNC_ABSORB:
                begin
                    if (done || bad)
                        bad = 1'b1;
                    else
                    begin
                        bytes_in++;
                        blk[fill & 63] = d;
                        fill = (fill & 63) + 1;
                        bit_total += 64'd8;
                        if (bit_total == 64'd0)
                            bad = 1'b1;
                        if (fill == 64)
                            compress();
                    end
                end
                FUNC_FINISH:
                begin
                    if (bad)
                    begin
                        r.word = '0;
                        r.index = '0;
                        r.last = 1'b1;
                        r.err = 1'b1;
                        expected_words.push_back(r);
                        error_results++;
                    end
                    else
                    begin
                        if (!done)
                            pad_message();
                        done = 1'b1;
                        for (i = 0; i < 5; i++)
                        begin
                            r.word = chain[i];
                            r.index = i[2:0];
                            r.last = (i[2:0] == LAST_INDEX);
                            r.err = 1'b0;
                            expected_words.push_back(r);
                        end
                        digests++;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] index, logic last,
                                 logic err);
            digest_out_t r;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word=%h index=%0d last=%b err=%b",
                         $time, word, index, last, err);
                mismatches++;
                return;
            end
            r = expected_words.pop_front();
            if (word !== r.word)
            begin
                $display("%0t: digest word expected %h actual %h", $time, r.word, word);
                mismatches++;
            end
            if (index !== r.index)
            begin
                $display("%0t: word index expected %0d actual %0d", $time, r.index, index);
                mismatches++;
            end
            if (last !== r.last)
            begin
                $display("%0t: last flag expected %b actual %b", $time, r.last, last);
                mismatches++;
            end
            if (err !== r.err)
            begin
                $display("%0t: error flag expected %b actual %b", $time, r.err, err);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench for the SHA-1 stream hasher: stimulus, result monitor and watchdog.
module tb_top;

    import sha1sh_pkg::*;
    import sha1_digest_check_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 200;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    digest_tracker trk;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int messages = 0;
    int quiet_cycles = 0;

    sha1_stream_hasher dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offers one command and waits until the transfer completes.
    task automatic send_item(func_t f, logic [7:0] d);
        // Each idle cycle is drawn on its own, so about a third of the cycles stay idle.
        while (gaps_on && $urandom_range(99) < 33)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        trk.note_command(f, d);
        if (f != FUNC_NONE)
            items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (trk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(bit with_start, int len, bit noisy);
        int i;
        if (with_start)
            send_item(FUNC_START, 8'($urandom));
        for (i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(99) < 5)
                send_item(FUNC_NONE, 8'($urandom));
            send_item(FUNC_ABSORB, 8'($urandom));
        end
        send_item(FUNC_FINISH, 8'($urandom));
        messages++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(99) < 33);
        end
    end

    // Result monitor and watchdog.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                    trk.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast, m_tuser[0]);
                if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("sha1_stream_hasher test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int len;
        int pick;
        int msg_no;
        int lens [8];
        lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        trk = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty message straight out of reset, repeated finish, late byte,
        // finish in error, ignored selector, short messages with extreme bytes.
        send_item(FUNC_FINISH, 8'h00);
        send_item(FUNC_FINISH, 8'hFF);
        send_item(FUNC_ABSORB, 8'h00);
        send_item(FUNC_FINISH, 8'h00);
        send_item(FUNC_NONE, 8'hFF);
        send_item(FUNC_START, 8'hFF);
        send_item(FUNC_ABSORB, 8'h61);
        send_item(FUNC_ABSORB, 8'h62);
        send_item(FUNC_NONE, 8'h00);
        send_item(FUNC_ABSORB, 8'h63);
        send_item(FUNC_FINISH, 8'hFF);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_ABSORB, 8'hFF);
        send_item(FUNC_ABSORB, 8'h00);
        send_item(FUNC_ABSORB, 8'h80);
        send_item(FUNC_FINISH, 8'h00);
        send_item(FUNC_FINISH, 8'h00);
        send_item(FUNC_ABSORB, 8'h5A);
        send_item(FUNC_FINISH, 8'hA5);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_FINISH, 8'h00);
        drain();

        // Random part: mostly well-formed messages, lengths biased toward padding edges.
        items_sent = 0;
        msg_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            gaps_on = !(items_sent >= 80 && items_sent < 130);
            if (msg_no == 2)
                hold_req = 1'b1;
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(99) < 70)
                    len = $urandom_range(0, 12);
                else
                    len = lens[$urandom_range(0, 7)];
                send_message($urandom_range(99) < 90, len, 1'b1);
                if ($urandom_range(99) < 25)
                    send_item(FUNC_FINISH, 8'($urandom));
                if ($urandom_range(99) < 10)
                begin
                    send_item(FUNC_ABSORB, 8'($urandom));
                    send_item(FUNC_FINISH, 8'($urandom));
                end
            end
            else
            begin
                pick = $urandom_range(1, 4);
                repeat (pick) send_item(func_t'($urandom_range(0, 3)), 8'($urandom));
            end
            msg_no++;
            // Let the output side empty out now and then before the next message.
            if (msg_no % 5 == 0)
                drain();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        drain();
        repeat (300) @(posedge clk);

        $display("Covered %0d messages, %0d bytes absorbed, %0d digests and %0d error results,",
                 messages, trk.bytes_in, trk.digests, trk.error_results);
        $display("with %0d result transfers checked under random stalls and a long hold-off.",
                 trk.words_seen);
        if (trk.mismatches == 0 && trk.pending() == 0)
            $display("sha1_stream_hasher test passed");
        else
            $display("sha1_stream_hasher test failed");
        $finish;
    end

endmodule
